@@ design/json_string_escaper_core_assert.svh @@
// Assertion macros used by the checker file jse_checker.sv.
`ifndef JSON_STRING_ESCAPER_CORE_ASSERT_SVH
`define JSON_STRING_ESCAPER_CORE_ASSERT_SVH

// Implication checked in the next cycle, masked while reset is high.
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("json escaper check failed");

// Implication checked in the next cycle, also during reset.
`define JSE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("json escaper check failed");

`endif

@@ design/jse_pkg.sv @@
`timescale 1ns / 1ps

package jse_pkg;

  localparam int MaxBytes = 8;
  localparam int IdxW     = $clog2(MaxBytes);

  typedef logic [7:0] byte_t;
  typedef logic [MaxBytes-1:0][7:0] byte_vec_t;
  typedef logic [IdxW-1:0] idx_t;

  localparam byte_t CharQuote     = 8'h22;
  localparam byte_t CharBackslash = 8'h5C;
  localparam byte_t CharSlash     = 8'h2F;
  localparam byte_t CharU         = 8'h75;
  localparam byte_t CharZero      = 8'h30;
  localparam byte_t CharLowerA    = 8'h61;
  localparam byte_t CharUpperA    = 8'h41;
  localparam byte_t CharB         = 8'h62;
  localparam byte_t CharF         = 8'h66;
  localparam byte_t CharN         = 8'h6E;
  localparam byte_t CharR         = 8'h72;
  localparam byte_t CharT         = 8'h74;

  localparam logic [15:0] UnitBackspace = 16'h0008;
  localparam logic [15:0] UnitTab       = 16'h0009;
  localparam logic [15:0] UnitNewline   = 16'h000A;
  localparam logic [15:0] UnitFormFeed  = 16'h000C;
  localparam logic [15:0] UnitReturn    = 16'h000D;
  localparam logic [15:0] UnitQuote     = 16'h0022;
  localparam logic [15:0] UnitSlash     = 16'h002F;
  localparam logic [15:0] UnitBackslash = 16'h005C;

  function automatic byte_t hex_digit(input logic [3:0] nib, input logic upper);
    byte_t base;
    base = upper ? CharUpperA : CharLowerA;
    if (nib < 4'd10) begin
      return byte_t'(CharZero + {4'd0, nib});
    end
    return byte_t'(base + {4'd0, nib} - 8'd10);
  endfunction

endpackage

@@ design/json_string_escaper_core.sv @@
`timescale 1ns / 1ps
// JSON string escaper: one UTF-16 code unit per input word, escaped bytes out.
// A word is registered in the byte buffer when accepted; its bytes then pass
// one by one through the output register. Throughput: one output byte per
// cycle unless out_ready stalls; a word of n bytes (1..8) holds the input
// until its last byte moves on, so plain ASCII streams one word per cycle.
// Reset (rst, synchronous, active high) empties both stages and sets
// hex_upper_case to 0 (lower-case hex digits).
module json_string_escaper_core (
  input  logic                        clk,
  input  logic                        rst,
  // config
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 code_unit,
  input  logic                        is_first,
  input  logic                        is_last,
  input  logic                        empty_string,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        last_of_item
);

  logic hex_upper_case;

  // ---------------------------------------------------------------------------
  // Expansion: the whole escaped byte string of one word, built in one pass.
  // ---------------------------------------------------------------------------
  jse_pkg::byte_t     letter;
  jse_pkg::byte_t     body [6];
  logic [2:0]         body_len;   // 1, 2 or 6
  logic [3:0]         total_len;  // up to 8
  logic [3:0]         close_pos;
  jse_pkg::byte_vec_t exp_bytes;
  jse_pkg::idx_t      exp_last_idx;

  // Short escape letter; zero means the unit has none.
  always_comb begin
    case (code_unit)
      jse_pkg::UnitQuote:     letter = jse_pkg::CharQuote;
      jse_pkg::UnitBackslash: letter = jse_pkg::CharBackslash;
      jse_pkg::UnitSlash:     letter = jse_pkg::CharSlash;
      jse_pkg::UnitBackspace: letter = jse_pkg::CharB;
      jse_pkg::UnitFormFeed:  letter = jse_pkg::CharF;
      jse_pkg::UnitNewline:   letter = jse_pkg::CharN;
      jse_pkg::UnitReturn:    letter = jse_pkg::CharR;
      jse_pkg::UnitTab:       letter = jse_pkg::CharT;
      default:                letter = 8'h00;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      body[k] = 8'h00;
    end
    if (letter != 8'h00) begin
      body[0]  = jse_pkg::CharBackslash;
      body[1]  = letter;
      body_len = 3'd2;
    end else if (code_unit[15:7] == 9'd0) begin
      // raw pass-through, control characters included
      body[0]  = code_unit[7:0];
      body_len = 3'd1;
    end else begin
      body[0]  = jse_pkg::CharBackslash;
      body[1]  = jse_pkg::CharU;
      body[2]  = jse_pkg::hex_digit(code_unit[15:12], hex_upper_case);
      body[3]  = jse_pkg::hex_digit(code_unit[11:8], hex_upper_case);
      body[4]  = jse_pkg::hex_digit(code_unit[7:4], hex_upper_case);
      body[5]  = jse_pkg::hex_digit(code_unit[3:0], hex_upper_case);
      body_len = 3'd6;
    end
  end

  always_comb begin
    exp_bytes = '0;
    close_pos = {3'd0, is_first} + {1'b0, body_len};
    total_len = close_pos + {3'd0, is_last};
    if (empty_string) begin
      exp_bytes[0] = jse_pkg::CharQuote;
      exp_bytes[1] = jse_pkg::CharQuote;
      total_len    = 4'd2;
    end else begin
      if (is_first) begin
        exp_bytes[0] = jse_pkg::CharQuote;
        for (int k = 0; k < 6; k++) begin
          exp_bytes[k+1] = body[k];
        end
      end else begin
        for (int k = 0; k < 6; k++) begin
          exp_bytes[k] = body[k];
        end
      end
      // closing quote lands right after the body
      for (int i = 0; i < jse_pkg::MaxBytes; i++) begin
        if (is_last && close_pos == 4'(i)) begin
          exp_bytes[i] = jse_pkg::CharQuote;
        end
      end
    end
    exp_last_idx = jse_pkg::idx_t'(total_len - 4'd1);
  end

  // ---------------------------------------------------------------------------
  // Byte buffer (holds one expanded word) feeding the output register.
  // ---------------------------------------------------------------------------
  logic               buf_valid;
  jse_pkg::byte_vec_t buf_bytes;
  jse_pkg::idx_t      buf_last_idx;
  jse_pkg::idx_t      idx;

  logic in_fire;
  logic buf_adv;   // buffer hands a byte to the output register
  logic buf_done;  // ...and it was the word's last byte

  assign in_fire  = in_valid && in_ready;
  assign buf_adv  = buf_valid && (!out_valid || out_ready);
  assign buf_done = buf_adv && (idx == buf_last_idx);
  // take the next word in the same cycle the last byte moves on
  assign in_ready = !buf_valid || buf_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_upper_case <= 1'b0;
      buf_valid      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hex_upper_case <= cfg_wr_data;
      end

      if (in_fire) begin
        buf_valid    <= 1'b1;
        buf_bytes    <= exp_bytes;
        buf_last_idx <= exp_last_idx;
        idx          <= '0;
      end else begin
        if (buf_adv) begin
          idx <= idx + 1'b1;
        end
        if (buf_done) begin
          buf_valid <= 1'b0;
        end
      end

      if (buf_adv) begin
        out_valid    <= 1'b1;
        out_byte     <= buf_bytes[idx];
        last_of_item <= (idx == buf_last_idx);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/jse_checker.sv @@
`timescale 1ns / 1ps
`include "json_string_escaper_core_assert.svh"

module jse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        last_of_item
);

  // a stalled byte stays put
  `JSE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte))
  // bytes of one word come back to back
  `JSE_ASSERT_NEXT(a_word_gapless, clk, rst, out_valid && out_ready && !last_of_item, out_valid)
  // a waiting input word is not withdrawn
  `JSE_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid)
  // reset empties both stages
  `JSE_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && in_ready)

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .last_of_item (last_of_item)
);
